>>> rtl/gcp_pkg.sv
// Shared types, constants and row shaping function for the glyph centering block.
package gcp_pkg;

    localparam int MAX_CELL  = 64;
    localparam int ROW_W     = 64;
    localparam int DIM_W     = 7;
    localparam int OFF_W     = 6;
    localparam int NUM_W     = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE    = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd32;
    localparam logic [DIM_W-1:0] DIM_MAX   = 7'd64;
    localparam logic [DIM_W-1:0] CELL_MAX  = DIM_W'(MAX_CELL);

    // Clamped cell geometry, derived from the configuration registers.
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] size;
        logic [OFF_W-1:0] xoff;
        logic [OFF_W-1:0] yup;
    } geom_t;

    // One result row as produced by the sequencer.
    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
        logic [NUM_W-1:0] num;
        logic             last;
        logic             done;
    } emit_t;

    // Keep the top n bits of a row, n in 1..64 (a shift by 64 yields zero).
    function automatic logic [ROW_W-1:0] top_mask(input logic [DIM_W-1:0] n);
        top_mask = ~({ROW_W{1'b1}} >> n);
    endfunction

    // Crop to glyph width, move right by the left offset, crop to cell width.
    function automatic logic [ROW_W-1:0] shape_row(input logic [ROW_W-1:0] glyph,
                                                   input geom_t            g);
        shape_row = ((glyph & top_mask(g.width)) >> g.xoff) & top_mask(g.size);
    endfunction

endpackage

>>> rtl/gcp_cfg.sv
// Configuration registers and clamped cell geometry.
module gcp_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [gcp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gcp_pkg::DIM_W-1:0]        cfg_wdata,
    output gcp_pkg::geom_t                   geom,
    output logic                             cfg_clear
);

    logic [gcp_pkg::DIM_W-1:0] width_reg;
    logic [gcp_pkg::DIM_W-1:0] height_reg;
    logic [gcp_pkg::DIM_W-1:0] size_reg;
    logic [gcp_pkg::DIM_W-1:0] w_c;
    logic [gcp_pkg::DIM_W-1:0] h_c;
    logic [gcp_pkg::DIM_W-1:0] s_c;
    logic [gcp_pkg::DIM_W-1:0] xdiff;
    logic [gcp_pkg::DIM_W-1:0] ydiff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= gcp_pkg::DIM_RESET;
            height_reg <= gcp_pkg::DIM_RESET;
            size_reg   <= gcp_pkg::DIM_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                gcp_pkg::REG_GLYPH_WIDTH:  width_reg  <= cfg_wdata;
                gcp_pkg::REG_GLYPH_HEIGHT: height_reg <= cfg_wdata;
                gcp_pkg::REG_CELL_SIZE:    size_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Any write to a known register restarts the cell.
    assign cfg_clear = cfg_we && (cfg_index == gcp_pkg::REG_GLYPH_WIDTH ||
                                  cfg_index == gcp_pkg::REG_GLYPH_HEIGHT ||
                                  cfg_index == gcp_pkg::REG_CELL_SIZE);

    always_comb begin
        w_c = (width_reg == '0) ? gcp_pkg::DIM_W'(1) :
              (width_reg > gcp_pkg::DIM_MAX) ? gcp_pkg::DIM_MAX : width_reg;
        h_c = (height_reg == '0) ? gcp_pkg::DIM_W'(1) :
              (height_reg > gcp_pkg::DIM_MAX) ? gcp_pkg::DIM_MAX : height_reg;
        s_c = (size_reg == '0) ? gcp_pkg::DIM_W'(1) :
              (size_reg > gcp_pkg::CELL_MAX) ? gcp_pkg::CELL_MAX : size_reg;
        xdiff = (s_c > w_c) ? (s_c - w_c) : '0;
        ydiff = (s_c > h_c) ? (s_c - h_c) : '0;
        geom.width  = w_c;
        geom.height = h_c;
        geom.size   = s_c;
        geom.xoff   = xdiff[gcp_pkg::DIM_W-1:1];
        geom.yup    = ydiff[gcp_pkg::DIM_W-1:1];
    end

endmodule

>>> rtl/gcp_seq.sv
// Input holding register and row sequencer: top padding, glyph row, bottom padding.
module gcp_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gcp_pkg::ROW_W-1:0]     s_tdata,
    input  gcp_pkg::geom_t                geom,
    input  logic                          cfg_clear,
    input  logic                          out_free,
    output gcp_pkg::emit_t                emit
);

    logic                          work_valid_reg;
    logic                          work_valid_next;
    logic [gcp_pkg::ROW_W-1:0]     glyph_reg;
    logic                          sent_reg;
    logic                          sent_next;
    logic [gcp_pkg::DIM_W-1:0]     cnt_reg;
    logic [gcp_pkg::DIM_W-1:0]     cnt_next;
    logic [gcp_pkg::DIM_W-1:0]     taken_reg;
    logic [gcp_pkg::DIM_W-1:0]     taken_next;

    logic [gcp_pkg::DIM_W-1:0]     cnt_inc;
    logic [gcp_pkg::DIM_W-1:0]     taken_inc;
    logic                          last_glyph_row;
    logic                          top_phase;
    logic                          emit_any;
    logic                          item_done;
    logic                          step;
    logic [gcp_pkg::ROW_W-1:0]     row_val;

    assign cnt_inc        = cnt_reg + gcp_pkg::DIM_W'(1);
    assign taken_inc      = taken_reg + gcp_pkg::DIM_W'(1);
    assign last_glyph_row = taken_inc >= geom.height;
    assign top_phase      = !sent_reg && (taken_reg == '0) &&
                            (cnt_reg < {1'b0, geom.yup});

    always_comb begin
        if (top_phase) begin
            emit_any  = 1'b1;
            row_val   = '0;
            item_done = 1'b0;
        end else if (!sent_reg) begin
            // Glyph row; drop it when the cell is already full.
            emit_any  = cnt_reg < geom.size;
            row_val   = gcp_pkg::shape_row(glyph_reg, geom);
            item_done = !last_glyph_row || (cnt_inc >= geom.size);
        end else begin
            emit_any  = 1'b1;
            row_val   = '0;
            item_done = cnt_inc >= geom.size;
        end
    end

    assign step     = work_valid_reg && (out_free || !emit_any);
    assign s_tready = !work_valid_reg || (step && item_done);

    always_comb begin
        emit.valid = step && emit_any;
        emit.row   = row_val;
        emit.num   = cnt_reg[gcp_pkg::NUM_W-1:0];
        emit.last  = item_done;
        emit.done  = cnt_inc == geom.size;
    end

    always_comb begin
        sent_next       = sent_reg;
        cnt_next        = cnt_reg;
        taken_next      = taken_reg;
        work_valid_next = work_valid_reg;
        if (step) begin
            if (emit_any) begin
                cnt_next = cnt_inc;
            end
            if (item_done) begin
                sent_next       = 1'b0;
                work_valid_next = 1'b0;
                if (last_glyph_row) begin
                    cnt_next   = '0;
                    taken_next = '0;
                end else begin
                    taken_next = taken_inc;
                end
            end else if (!top_phase) begin
                sent_next = 1'b1;
            end
        end
        if (s_tvalid && s_tready) begin
            work_valid_next = 1'b1;
        end
        if (cfg_clear) begin
            sent_next  = 1'b0;
            cnt_next   = '0;
            taken_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
            sent_reg       <= 1'b0;
            cnt_reg        <= '0;
            taken_reg      <= '0;
        end else begin
            work_valid_reg <= work_valid_next;
            sent_reg       <= sent_next;
            cnt_reg        <= cnt_next;
            taken_reg      <= taken_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            glyph_reg <= s_tdata;
        end
    end

endmodule

>>> rtl/glyph_center_pad_repack_unit.sv
// Top level of the glyph centering and padding block.
//
// Usage:
//   Input stream (s_*): one glyph row per transfer, left-justified, bit 63 is
//   the leftmost pixel. Output stream (m_*): one cell row per transfer, the
//   glyph centered horizontally in a square cell, unused low bits zero.
//   m_tuser carries the row index within the cell and a flag on the cell's
//   final row; m_tlast marks the last row caused by one input transfer.
//   Before a glyph's first row, floor((size-height)/2) zero rows go out; after
//   its last row, zero rows complete the cell. Rows that fall past the cell
//   are dropped, so an input transfer can cause no output at all.
//   Each input row passes through the holding register, then the output
//   register. Throughput: one input row per cycle while no padding is due
//   and the output is not stalled; the input holds off for each padding row.
//   Configuration: write cfg_wdata to register cfg_index while the block is
//   idle; any write to a known register restarts the cell. Reset sets all
//   sizes to 32, clears the counters and empties both registers.
//   Stall: when m_tready is low the output row holds and the sequencer stops;
//   the input still takes a row into the holding register if it is empty.
module glyph_center_pad_repack_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [63:0]                       s_tdata,   // [63:0] glyph_row
    // Output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [63:0]                       m_tdata,   // [63:0] cell_row
    output logic [6:0]                        m_tuser,   // [5:0] row_number, [6] cell_done
    output logic                              m_tlast,   // run_last
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [gcp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gcp_pkg::DIM_W-1:0]         cfg_wdata
);

    gcp_pkg::geom_t                geom;
    gcp_pkg::emit_t                emit;
    logic                          cfg_clear;
    logic                          out_free;

    logic                          out_valid_reg;
    logic [gcp_pkg::ROW_W-1:0]     out_row_reg;
    logic [gcp_pkg::NUM_W-1:0]     out_num_reg;
    logic                          out_last_reg;
    logic                          out_done_reg;

    gcp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .geom      (geom),
        .cfg_clear (cfg_clear)
    );

    gcp_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .geom      (geom),
        .cfg_clear (cfg_clear),
        .out_free  (out_free),
        .emit      (emit)
    );

    // The output register takes a new row when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load payload only on a new row; hold it during a stall.
    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            out_row_reg  <= emit.row;
            out_num_reg  <= emit.num;
            out_last_reg <= emit.last;
            out_done_reg <= emit.done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_row_reg;
    assign m_tuser  = {out_done_reg, out_num_reg};
    assign m_tlast  = out_last_reg;

endmodule

>>> verif/tb_glyph_center_pad_repack_unit.sv
// Self-checking testbench for the glyph centering and padding block.
module tb_glyph_center_pad_repack_unit;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [gcp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int RANDOM_ROWS   = 420;
    // Ready cycles to let pass before a register write, halfway and at the end of the run,
    // well past the two-stage latency, so that rows that cause no output drain.
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic {PLAN_DATA, PLAN_WRITE} plan_kind_t;

    // One expected cell row, in the order the output stream carries it.
    typedef struct packed {
        logic [gcp_pkg::ROW_W-1:0] row;
        logic [gcp_pkg::NUM_W-1:0] num;
        logic                      last;
        logic                      done;
    } cell_row_t;

    typedef struct {
        plan_kind_t                    kind;
        logic [gcp_pkg::CFG_IDX_W-1:0] idx;
        logic [gcp_pkg::ROW_W-1:0]     value;
        bit                            known;   // single cell row typed in by hand
        cell_row_t                     want;
    } plan_step_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [63:0]                   s_tdata = '0;      // [63:0] glyph_row
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [63:0]                   m_tdata;           // [63:0] cell_row
    logic [6:0]                    m_tuser;           // [5:0] row_number, [6] cell_done
    logic                          m_tlast;           // run_last
    logic                          cfg_we = 1'b0;
    logic [gcp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gcp_pkg::DIM_W-1:0]     cfg_wdata = '0;

    glyph_center_pad_repack_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Predictor copy of the registers and the two counters.
    logic [gcp_pkg::DIM_W-1:0] glyph_w_reg   = gcp_pkg::DIM_RESET;
    logic [gcp_pkg::DIM_W-1:0] glyph_h_reg   = gcp_pkg::DIM_RESET;
    logic [gcp_pkg::DIM_W-1:0] cell_side_reg = gcp_pkg::DIM_RESET;
    logic [gcp_pkg::DIM_W-1:0] rows_taken    = '0;
    logic [gcp_pkg::DIM_W-1:0] row_ctr       = '0;

    cell_row_t  cell_rows_due[$];
    cell_row_t  got_want;
    plan_step_t plan[$];
    int         mismatches = 0;
    int         rows_sent = 0;
    int         ready_left = 0;
    int         ready_pick;

    // ---------------------------------------------------------------- predictor

    // Top n bits of a row set, n in 1..64.
    function automatic logic [gcp_pkg::ROW_W-1:0] left_bits(int n);
        return {gcp_pkg::ROW_W{1'b1}} << (gcp_pkg::ROW_W - n);
    endfunction

    // Zero counts as one, anything above the ceiling counts as the ceiling.
    function automatic int clamp_dim(logic [gcp_pkg::DIM_W-1:0] v, int hi);
        if (v == 0) return 1;
        return (int'(v) > hi) ? hi : int'(v);
    endfunction

    function automatic void push_cell_row(logic [gcp_pkg::ROW_W-1:0] row, int side);
        cell_row_t e;
        e.row  = row;
        e.num  = row_ctr[gcp_pkg::NUM_W-1:0];
        e.last = 1'b0;
        e.done = (int'(row_ctr) + 1 == side);
        cell_rows_due.push_back(e);
        row_ctr = row_ctr + 7'd1;
    endfunction

    // Queue the cell rows that one glyph row causes; return how many.
    function automatic int predict_cell_rows(logic [gcp_pkg::ROW_W-1:0] glyph);
        int                        wide;
        int                        tall;
        int                        side;
        int                        xoff;
        int                        yup;
        int                        n;
        logic [gcp_pkg::ROW_W-1:0] row;
        cell_row_t                 tail;
        wide = clamp_dim(glyph_w_reg, gcp_pkg::ROW_W);
        tall = clamp_dim(glyph_h_reg, gcp_pkg::ROW_W);
        side = clamp_dim(cell_side_reg, gcp_pkg::MAX_CELL);
        xoff = (side > wide) ? (side - wide) / 2 : 0;
        yup  = (side > tall) ? (side - tall) / 2 : 0;
        n    = 0;
        // top padding before the first glyph row
        if (rows_taken == 0) begin
            while (int'(row_ctr) < yup) begin
                push_cell_row('0, side);
                n++;
            end
        end
        row = ((glyph & left_bits(wide)) >> xoff) & left_bits(side);
        // rows of a tall glyph that fall past the cell are dropped
        if (int'(row_ctr) < side) begin
            push_cell_row(row, side);
            n++;
        end
        rows_taken = rows_taken + 7'd1;
        if (int'(rows_taken) >= tall) begin
            while (int'(row_ctr) < side) begin
                push_cell_row('0, side);
                n++;
            end
            rows_taken = '0;
            row_ctr    = '0;
        end
        if (n > 0) begin
            tail      = cell_rows_due.pop_back();
            tail.last = 1'b1;
            cell_rows_due.push_back(tail);
        end
        return n;
    endfunction

    function automatic void apply_reg(logic [gcp_pkg::CFG_IDX_W-1:0] idx,
                                      logic [gcp_pkg::DIM_W-1:0] val);
        case (idx)
            gcp_pkg::REG_GLYPH_WIDTH:  glyph_w_reg   = val;
            gcp_pkg::REG_GLYPH_HEIGHT: glyph_h_reg   = val;
            gcp_pkg::REG_CELL_SIZE:    cell_side_reg = val;
            default:                   return;
        endcase
        // any real register write restarts the cell
        rows_taken = '0;
        row_ctr    = '0;
    endfunction

    // ---------------------------------------------------------------- checker

    function automatic void check_field(string what, logic [gcp_pkg::ROW_W-1:0] want_v,
                                        logic [gcp_pkg::ROW_W-1:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t %s: expected %h, got %h", $time, what, want_v, got_v);
            mismatches++;
        end
    endfunction

    // Compare every output transfer against the oldest expected cell row.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (cell_rows_due.size() == 0) begin
                $display("%0t unexpected cell row: expected none, got %h", $time, m_tdata);
                mismatches++;
            end else begin
                got_want = cell_rows_due.pop_front();
                check_field("cell_row", got_want.row, m_tdata);
                check_field("row_number", gcp_pkg::ROW_W'(got_want.num),
                            gcp_pkg::ROW_W'(m_tuser[5:0]));
                check_field("cell_done", gcp_pkg::ROW_W'(got_want.done),
                            gcp_pkg::ROW_W'(m_tuser[6]));
                check_field("run_last", gcp_pkg::ROW_W'(got_want.last),
                            gcp_pkg::ROW_W'(m_tlast));
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // Mostly short ready bursts and short stalls, some long clean stretches,
    // a few long stalls.
    always @(negedge aclk) begin
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 60) begin
                m_tready   <= 1'b1;
                ready_left <= $urandom_range(0, 15);
            end else if (ready_pick < 70) begin
                m_tready   <= 1'b1;
                ready_left <= $urandom_range(50, 150);
            end else if (ready_pick < 95) begin
                m_tready   <= 1'b0;
                ready_left <= $urandom_range(0, 2);
            end else begin
                m_tready   <= 1'b0;
                ready_left <= $urandom_range(10, 40);
            end
        end
    end

    // ---------------------------------------------------------------- sender

    // Present one glyph row, hold it until the transfer, then predict.
    task automatic send_row(input logic [gcp_pkg::ROW_W-1:0] glyph, output int n);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= glyph;
        do @(posedge aclk); while (!s_tready);
        n = predict_cell_rows(glyph);
        rows_sent++;
    endtask

    task automatic idle_sender(int n);
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // Drop valid, drain every expected row, then let the block go quiet.
    task automatic settle();
        int quiet;
        quiet = 0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (cell_rows_due.size() != 0) @(posedge aclk);
        while (quiet < SETTLE_CYCLES) begin
            @(posedge aclk);
            if (m_tready) quiet++;
        end
    endtask

    task automatic write_reg(logic [gcp_pkg::CFG_IDX_W-1:0] idx,
                             logic [gcp_pkg::DIM_W-1:0] val);
        settle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        apply_reg(idx, val);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly no gap, some short ones, a few long ones.
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [gcp_pkg::ROW_W-1:0] pick_glyph_row();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            2:       return gcp_pkg::ROW_W'(1) << $urandom_range(0, gcp_pkg::ROW_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Extremes, out-of-range codes and in-range values.
    function automatic logic [gcp_pkg::DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return 7'd1;
            1:       return gcp_pkg::DIM_MAX;
            2:       return 7'd0;
            3:       return 7'd127;
            4:       return gcp_pkg::DIM_W'($urandom_range(65, 127));
            5:       return gcp_pkg::DIM_W'($urandom_range(1, 8));
            default: return gcp_pkg::DIM_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [gcp_pkg::CFG_IDX_W-1:0] pick_reg();
        case ($urandom_range(0, 15))
            0:               return REG_UNUSED;
            1, 2, 3, 4, 5:   return gcp_pkg::REG_GLYPH_WIDTH;
            6, 7, 8, 9, 10:  return gcp_pkg::REG_GLYPH_HEIGHT;
            default:         return gcp_pkg::REG_CELL_SIZE;
        endcase
    endfunction

    // ---------------------------------------------------------------- directed plan

    function automatic plan_step_t plan_write(logic [gcp_pkg::CFG_IDX_W-1:0] idx,
                                              logic [gcp_pkg::DIM_W-1:0] val);
        plan_step_t p;
        p.kind  = PLAN_WRITE;
        p.idx   = idx;
        p.value = gcp_pkg::ROW_W'(val);
        p.known = 1'b0;
        p.want  = '0;
        return p;
    endfunction

    function automatic plan_step_t plan_row(logic [gcp_pkg::ROW_W-1:0] glyph);
        plan_step_t p;
        p.kind  = PLAN_DATA;
        p.idx   = '0;
        p.value = glyph;
        p.known = 1'b0;
        p.want  = '0;
        return p;
    endfunction

    // A glyph row whose single cell row is plain from the settings in force.
    function automatic plan_step_t plan_row_known(logic [gcp_pkg::ROW_W-1:0] glyph,
                                                  logic [gcp_pkg::ROW_W-1:0] row,
                                                  logic [gcp_pkg::NUM_W-1:0] num,
                                                  logic done);
        plan_step_t p;
        p = plan_row(glyph);
        p.known     = 1'b1;
        p.want.row  = row;
        p.want.num  = num;
        p.want.last = 1'b1;
        p.want.done = done;
        return p;
    endfunction

    // ---------------------------------------------------------------- main

    initial begin
        int  n;
        int  tall;
        int  rows;
        bit  steady;
        bit  drained;

        // Reset sizes are 32: the glyph fills the left half, no padding yet.
        plan.push_back(plan_row_known(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
                                      6'd0, 1'b0));
        // pixels past the glyph width are ignored
        plan.push_back(plan_row_known(64'h0000_0000_FFFF_FFFF, 64'h0, 6'd1, 1'b0));
        plan.push_back(plan_row_known(64'h8000_0001_8000_0001, 64'h8000_0001_0000_0000,
                                      6'd2, 1'b0));
        // Full-width glyph, two rows high, in the largest cell: heavy top padding.
        plan.push_back(plan_write(gcp_pkg::REG_GLYPH_WIDTH, gcp_pkg::DIM_MAX));
        plan.push_back(plan_write(gcp_pkg::REG_GLYPH_HEIGHT, 7'd2));
        plan.push_back(plan_write(gcp_pkg::REG_CELL_SIZE, gcp_pkg::CELL_MAX));
        plan.push_back(plan_row(64'hFFFF_FFFF_FFFF_FFFF));
        plan.push_back(plan_row(64'h8000_0000_0000_0001));
        // Zero and oversize codes: one-pixel glyph, cell clamped to the maximum.
        plan.push_back(plan_write(gcp_pkg::REG_GLYPH_WIDTH, 7'd0));
        plan.push_back(plan_write(gcp_pkg::REG_GLYPH_HEIGHT, 7'd1));
        plan.push_back(plan_write(gcp_pkg::REG_CELL_SIZE, 7'd127));
        plan.push_back(plan_row(64'hFFFF_FFFF_FFFF_FFFF));
        // Glyph wider than the cell: cropped at the cell edge.
        plan.push_back(plan_write(gcp_pkg::REG_GLYPH_WIDTH, 7'd127));
        plan.push_back(plan_write(gcp_pkg::REG_GLYPH_HEIGHT, 7'd0));
        plan.push_back(plan_write(gcp_pkg::REG_CELL_SIZE, 7'd8));
        plan.push_back(plan_row(64'hFFFF_FFFF_FFFF_FFFF));
        plan.push_back(plan_row(64'h0123_4567_89AB_CDEF));
        // Glyph taller than a one-pixel cell: later rows cause no output.
        plan.push_back(plan_write(gcp_pkg::REG_CELL_SIZE, 7'd1));
        plan.push_back(plan_write(gcp_pkg::REG_GLYPH_HEIGHT, 7'd3));
        plan.push_back(plan_row_known(64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                                      6'd0, 1'b1));
        plan.push_back(plan_row(64'hFFFF_FFFF_FFFF_FFFF));
        plan.push_back(plan_row(64'hFFFF_FFFF_FFFF_FFFF));
        plan.push_back(plan_row_known(64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 6'd0, 1'b1));
        // A write to the unused index must not restart the glyph.
        plan.push_back(plan_write(REG_UNUSED, 7'h55));
        plan.push_back(plan_row(64'hFFFF_FFFF_FFFF_FFFF));
        plan.push_back(plan_row(64'hFFFF_FFFF_FFFF_FFFF));
        plan.push_back(plan_row_known(64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                                      6'd0, 1'b1));
        // Small glyph centered both ways.
        plan.push_back(plan_write(gcp_pkg::REG_GLYPH_WIDTH, 7'd5));
        plan.push_back(plan_write(gcp_pkg::REG_GLYPH_HEIGHT, 7'd5));
        plan.push_back(plan_write(gcp_pkg::REG_CELL_SIZE, 7'd10));
        plan.push_back(plan_row(64'hF800_0000_0000_0000));
        plan.push_back(plan_row(64'h8800_0000_0000_0000));
        plan.push_back(plan_row(64'hA8FF_FFFF_FFFF_FFFF));
        plan.push_back(plan_row(64'h8800_0000_0000_0001));
        plan.push_back(plan_row(64'h5000_0000_0000_0000));

        // Hold reset, then release it on a falling edge.
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the directed plan.
        foreach (plan[i]) begin
            if (plan[i].kind == PLAN_WRITE) begin
                write_reg(plan[i].idx, plan[i].value[gcp_pkg::DIM_W-1:0]);
            end else begin
                send_row(plan[i].value, n);
                if (plan[i].known) begin
                    if (n != 1) begin
                        $display("%0t plan row %0d: expected 1 cell row, got %0d predicted",
                                 $time, i, n);
                        mismatches++;
                    end else begin
                        // swap the predicted row for the hand-typed one
                        void'(cell_rows_due.pop_back());
                        cell_rows_due.push_back(plan[i].want);
                    end
                end
                idle_sender(gap_cycles());
            end
        end

        // Random phases: new settings, then whole glyphs with random pixels,
        // now and then a glyph cut short.
        rows_sent = 0;
        drained   = 1'b0;
        while (rows_sent < RANDOM_ROWS) begin
            repeat ($urandom_range(1, 3)) write_reg(pick_reg(), pick_dim());
            steady = ($urandom_range(0, 3) == 0);
            tall   = clamp_dim(glyph_h_reg, gcp_pkg::ROW_W);
            repeat ($urandom_range(1, 3)) begin
                rows = tall;
                if ($urandom_range(0, 4) == 0) rows = $urandom_range(1, tall);
                for (int r = 0; r < rows; r++) begin
                    if (rows_sent >= RANDOM_ROWS) break;
                    // once, halfway, hold off until the output has caught up
                    if (!drained && rows_sent >= RANDOM_ROWS / 2) begin
                        drained = 1'b1;
                        settle();
                    end
                    send_row(pick_glyph_row(), n);
                    if (!steady) idle_sender(gap_cycles());
                end
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("glyph_center_pad_repack_unit: match");
        end else begin
            $display("glyph_center_pad_repack_unit: mismatch");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("glyph_center_pad_repack_unit: mismatch");
        $finish;
    end

endmodule

>>> files.f
rtl/gcp_pkg.sv
rtl/gcp_cfg.sv
rtl/gcp_seq.sv
rtl/glyph_center_pad_repack_unit.sv
verif/tb_glyph_center_pad_repack_unit.sv
